/* hw/rtl/rrts_pkg.sv */
// Package for the round-robin task table scheduler.
// Holds the sequencer state type, operation and status codes.
// No dependencies.
package rrts_pkg;

    localparam int unsigned ID_W  = 15;
    localparam int unsigned SCR_W = 7;

    localparam logic [ID_W-1:0] ID_MAX = 15'h7FFF;

    localparam logic [2:0] OP_TICK       = 3'd0;
    localparam logic [2:0] OP_ADD_NEW    = 3'd1;
    localparam logic [2:0] OP_ADD_SHARED = 3'd2;
    localparam logic [2:0] OP_ACTIVATE   = 3'd3;
    localparam logic [2:0] OP_DEACTIVATE = 3'd4;
    localparam logic [2:0] OP_KILL       = 3'd5;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_FULL    = 2'd1;
    localparam logic [1:0] STAT_UNKNOWN = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIND,
        ST_COUNT,
        ST_ADD,
        ST_SCHED,
        ST_PICK,
        ST_LOAD,
        ST_DONE
    } t_state;

endpackage

/* hw/rtl/round_robin_task_table_scheduler_core.sv */
// Round-robin task table scheduler core: task table, id lookup and scheduler.
// Depends on rrts_pkg (state type, operation and status codes).
//
// Usage: present a command word on i_op, i_task_id, i_screen_id and i_home with
// start high; it is taken at the clock edge where start is high and busy is low.
// busy stays high until the result word has been shown. The result appears on
// the o_ ports for exactly one cycle, marked by o_strobe; the receiver has no
// way to stall it and must take it in that cycle.
// Steps per command word: an add with a new screen scans for a free slot; add
// shared, activate, deactivate and kill first look the id up, add shared then
// scans for a free slot, and kill then checks the screen for other tasks; tick,
// deactivate and kill (unless it empties the table) run the round-robin search.
// Unused op codes and a tick on an empty table go straight to the result.
// Lookups and screen counting step one slot per cycle through the id/screen
// table read port, and the round-robin search visits one slot per cycle. Only
// one word is in work at a time; the next word can be taken in the cycle after
// the strobe.
// Reset (synchronous, i_rst_n low) empties the table, deselects any task and
// sets the next id to one; the table memory itself needs no clearing pass.
module round_robin_task_table_scheduler_core
    import rrts_pkg::*;
#(
    parameter int unsigned SLOTS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_op,
    input  logic [ID_W-1:0]  i_task_id,
    input  logic [SCR_W-1:0] i_screen_id,
    input  logic             i_home,
    output logic             o_strobe,
    output logic [1:0]       o_status,
    output logic [ID_W-1:0]  o_new_task_id,
    output logic             o_switched,
    output logic             o_run_valid,
    output logic [3:0]       o_run_slot,
    output logic [ID_W-1:0]  o_run_task_id,
    output logic [SCR_W-1:0] o_run_screen,
    output logic             o_first_run,
    output logic             o_release_screen,
    output logic [SCR_W-1:0] o_released_screen_id
);

    localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned KW = $clog2(SLOTS + 1);

    t_state r_state, n_state;

    logic [ID_W-1:0]  m_id  [SLOTS];
    logic [SCR_W-1:0] m_scr [SLOTS];
    logic [ID_W-1:0]  r_rd_id;
    logic [SCR_W-1:0] r_rd_scr;

    logic [SLOTS-1:0] r_occ, r_act, r_hom, r_started;
    logic [KW-1:0]    r_live;
    logic [ID_W-1:0]  r_next_id;

    logic [2:0]       r_op;
    logic [ID_W-1:0]  r_tid;
    logic [SCR_W-1:0] r_scr_in;
    logic             r_home_in;

    logic [KW-1:0]    r_k;
    logic             r_pv;
    logic [SW-1:0]    r_pidx;
    logic [SW-1:0]    r_s;
    logic [SCR_W-1:0] r_sscr;
    logic             r_other;
    logic [SW-1:0]    r_si;
    logic             r_hv;
    logic [SW-1:0]    r_hidx;
    logic [SW-1:0]    r_pick;
    logic             r_pick_v;

    logic [SW-1:0]    r_cur;
    logic             r_cur_v;
    logic [ID_W-1:0]  r_cur_id;
    logic [SCR_W-1:0] r_cur_scr;

    logic [1:0]       r_status;
    logic [ID_W-1:0]  r_new_id;
    logic             r_switched;
    logic             r_first;
    logic             r_rel;
    logic [SCR_W-1:0] r_rel_scr;

    logic [SW-1:0]    kidx;
    logic             k_more;
    logic             find_hit;
    logic             scan_end;
    logic             full;
    logic             sched_hit;
    logic [SW-1:0]    sched_start;
    logic [SW-1:0]    si_next;
    logic [SW-1:0]    rd_addr;
    logic             mem_we;
    logic [SCR_W-1:0] add_scr;
    logic [SW+3:0]    cur_ext;

    assign kidx      = r_k[SW-1:0];
    assign k_more    = (r_k < KW'(SLOTS));
    assign find_hit  = r_pv && r_occ[r_pidx] && (r_rd_id == r_tid) && (r_tid != '0);
    assign scan_end  = !r_pv && !k_more;
    assign full      = (r_live >= KW'(SLOTS));
    assign sched_hit = r_occ[r_si] && r_act[r_si];
    assign si_next   = (r_si == SW'(SLOTS - 1)) ? '0 : r_si + SW'(1);
    assign add_scr   = (r_op == OP_ADD_NEW) ? r_scr_in : r_sscr;

    always_comb begin
        sched_start = '0;
        if (r_cur_v) begin
            sched_start = (r_cur == SW'(SLOTS - 1)) ? '0 : r_cur + SW'(1);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_op)
                        OP_TICK:       n_state = (r_live != '0) ? ST_SCHED : ST_DONE;
                        OP_ADD_NEW:    n_state = ST_ADD;
                        OP_ADD_SHARED,
                        OP_ACTIVATE,
                        OP_DEACTIVATE,
                        OP_KILL:       n_state = ST_FIND;
                        default:       n_state = ST_DONE;
                    endcase
                end
            end
            ST_FIND: begin
                if (find_hit) begin
                    case (r_op)
                        OP_ADD_SHARED: n_state = ST_ADD;
                        OP_DEACTIVATE: n_state = ST_SCHED;
                        OP_KILL:       n_state = ST_COUNT;
                        default:       n_state = ST_DONE;
                    endcase
                end else if (scan_end) begin
                    n_state = ST_DONE;
                end
            end
            ST_COUNT: begin
                if (scan_end) begin
                    n_state = (r_live == KW'(1)) ? ST_DONE : ST_SCHED;
                end
            end
            ST_ADD: begin
                if (full || !k_more || !r_occ[kidx]) begin
                    n_state = ST_DONE;
                end
            end
            ST_SCHED: begin
                if (!k_more || sched_hit) begin
                    n_state = ST_PICK;
                end
            end
            ST_PICK:  n_state = r_pick_v ? ST_LOAD : ST_DONE;
            ST_LOAD:  n_state = ST_DONE;
            ST_DONE:  n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        busy     = 1'b1;
        o_strobe = 1'b0;
        rd_addr  = kidx;
        mem_we   = 1'b0;
        case (r_state)
            ST_IDLE:  busy = 1'b0;
            ST_ADD:   mem_we = !full && k_more && !r_occ[kidx];
            ST_PICK:  rd_addr = r_pick;
            ST_DONE:  o_strobe = 1'b1;
            default:  rd_addr = kidx;
        endcase
    end

    // task table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            m_id[kidx]  <= r_next_id;
            m_scr[kidx] <= add_scr;
        end
        r_rd_id  <= m_id[rd_addr];
        r_rd_scr <= m_scr[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_occ     <= '0;
            r_act     <= '0;
            r_hom     <= '0;
            r_started <= '0;
            r_live    <= '0;
            r_next_id <= ID_W'(1);
            r_cur_v   <= 1'b0;
            r_k       <= '0;
            r_pv      <= 1'b0;
            r_hv      <= 1'b0;
            r_other   <= 1'b0;
            r_pick_v  <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (start) begin
                        r_op       <= i_op;
                        r_tid      <= i_task_id;
                        r_scr_in   <= i_screen_id;
                        r_home_in  <= i_home;
                        r_status   <= STAT_OK;
                        r_new_id   <= '0;
                        r_switched <= (i_op == OP_TICK) && (r_live != '0);
                        r_first    <= 1'b0;
                        r_rel      <= 1'b0;
                        r_rel_scr  <= '0;
                    end
                end
                ST_FIND, ST_COUNT: begin
                    r_pidx <= kidx;
                    if (n_state == r_state) begin
                        r_pv <= k_more;
                        if (k_more) begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                    if (r_state == ST_FIND) begin
                        if (find_hit) begin
                            r_s    <= r_pidx;
                            r_sscr <= r_rd_scr;
                            if (r_op == OP_ACTIVATE) begin
                                r_act[r_pidx] <= 1'b1;
                            end
                            if (r_op == OP_DEACTIVATE) begin
                                r_act[r_pidx] <= 1'b0;
                                r_switched    <= 1'b1;
                            end
                        end else if (scan_end) begin
                            r_status <= STAT_UNKNOWN;
                        end
                    end else begin
                        if (r_pv && (r_pidx != r_s) && r_occ[r_pidx]
                                && (r_rd_scr == r_sscr)) begin
                            r_other <= 1'b1;
                        end
                        if (scan_end) begin
                            r_rel          <= !r_other;
                            r_rel_scr      <= r_other ? '0 : r_sscr;
                            r_occ[r_s]     <= 1'b0;
                            r_act[r_s]     <= 1'b0;
                            r_hom[r_s]     <= 1'b0;
                            r_started[r_s] <= 1'b0;
                            r_live         <= r_live - KW'(1);
                            r_switched     <= 1'b1;
                            if (r_live == KW'(1)) begin
                                r_cur_v <= 1'b0;
                            end
                        end
                    end
                end
                ST_ADD: begin
                    if (full || !k_more) begin
                        r_status <= STAT_FULL;
                    end else if (!r_occ[kidx]) begin
                        r_occ[kidx]     <= 1'b1;
                        r_act[kidx]     <= 1'b1;
                        r_hom[kidx]     <= r_home_in;
                        r_started[kidx] <= 1'b0;
                        r_live          <= r_live + KW'(1);
                        r_new_id        <= r_next_id;
                        r_next_id       <= (r_next_id == ID_MAX) ? ID_W'(1)
                                                                 : r_next_id + ID_W'(1);
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                ST_SCHED: begin
                    if (!k_more) begin
                        r_act    <= r_act | (r_occ & r_hom);
                        r_pick   <= r_hidx;
                        r_pick_v <= r_hv;
                    end else if (sched_hit) begin
                        r_pick   <= r_si;
                        r_pick_v <= 1'b1;
                    end else begin
                        if (r_occ[r_si] && r_hom[r_si] && (!r_hv || (r_si > r_hidx))) begin
                            r_hv   <= 1'b1;
                            r_hidx <= r_si;
                        end
                        r_si <= si_next;
                        r_k  <= r_k + KW'(1);
                    end
                end
                ST_PICK: begin
                    if (!r_pick_v) begin
                        r_cur_v <= 1'b0;
                    end
                end
                ST_LOAD: begin
                    r_cur             <= r_pick;
                    r_cur_v           <= 1'b1;
                    r_cur_id          <= r_rd_id;
                    r_cur_scr         <= r_rd_scr;
                    r_first           <= !r_started[r_pick];
                    r_started[r_pick] <= 1'b1;
                end
                default: begin
                end
            endcase
            // fresh scan on every state change
            if (n_state != r_state) begin
                r_k     <= '0;
                r_pv    <= 1'b0;
                r_hv    <= 1'b0;
                r_other <= 1'b0;
                r_si    <= sched_start;
            end
        end
    end

    assign cur_ext = {4'b0, r_cur};

    assign o_status             = r_status;
    assign o_new_task_id        = r_new_id;
    assign o_switched           = r_switched;
    assign o_run_valid          = r_cur_v;
    assign o_run_slot           = r_cur_v ? cur_ext[3:0] : 4'd0;
    assign o_run_task_id        = r_cur_v ? r_cur_id : '0;
    assign o_run_screen         = r_cur_v ? r_cur_scr : '0;
    assign o_first_run          = r_first;
    assign o_release_screen     = r_rel;
    assign o_released_screen_id = r_rel_scr;

endmodule
